// File: hw/rtl/vgss_pkg.sv
package vgss_pkg;

	localparam int CoordW = 20;
	localparam int DimW   = 7;
	localparam int ValW   = 16;
	localparam int SumW   = 28;
	localparam int CntW   = 17;
	localparam int CfgIdxW = 3;

	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_STAMP  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_DIM_X    = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DIM_Y    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DIM_Z    = 3'd5;

	typedef struct packed {
		logic [1:0]               kind;
		logic [17:0]              voxel_index;
		logic signed [ValW-1:0]   voxel_value;
		logic signed [CoordW-1:0] atom_x;
		logic signed [CoordW-1:0] atom_y;
		logic signed [CoordW-1:0] atom_z;
		logic                     is_fit_atom;
		logic                     last_atom;
	} vgss_in_t;

	typedef struct packed {
		logic signed [ValW-1:0] mean_density;
		logic                   outside_box;
	} vgss_out_t;

	// round(5*c/256) half away from zero, c up to 22 bits signed
	function automatic logic signed [15:0] grid_round(input logic signed [21:0] c);
		logic signed [24:0] p;
		logic [24:0] a;
		logic [24:0] r;
		begin
			p = 25'(c) * 25'sd5;
			a = p[24] ? 25'(-p) : 25'(p);
			r = (a + 25'd128) >> 8;
			grid_round = p[24] ? -16'(r[15:0]) : 16'(r[15:0]);
		end
	endfunction

endpackage

// File: hw/rtl/vgss_if.sv
interface vgss_in_if;
	import vgss_pkg::*;
	logic     valid;
	logic     ready;
	vgss_in_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vgss_out_if;
	import vgss_pkg::*;
	logic      valid;
	logic      ready;
	vgss_out_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/vgss_ram.sv
module vgss_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/voxel_grid_sphere_stamp_and_sample_unit.sv
// Voxel density grid with sphere stamping and atom sampling.
// Input channel in (valid/ready) carries one item: a voxel write, a sphere
// stamp at an atom, or an atom sample. Output channel out carries one result
// (mean density and outside flag) for each sample item marked last_atom.
// Configuration: cfg_we/cfg_index/cfg_data writes origin and dimensions;
// the user must write only while the block is idle (not enforced here).
// Each item passes S_ROUND, S_MUL and S_CEN; a voxel write is done in
// S_CEN. A sample then passes S_SADDR, S_SRD and S_SACC; one that closes
// a set adds a SumW (28) bit serial divide in S_DIV before S_OUT registers
// the result, and skips it when the set is poisoned. A stamp walks the
// (2R+1)^3 cube (729 points at R = 4) in S_WALK, writing memory at each
// point inside the sphere and grid, and passes S_MUL and S_CEN again on
// each of the 80 row changes; a fit atom stamp ends after S_CEN. The walk
// through the single RAM write port sets the rate. One item is in work at
// a time; in.ready is low meanwhile. The result sits in an output register;
// while the receiver stalls the block holds it and takes no new item.
// Reset clears the sequencer, sum, count and poison flag and restores the
// configuration defaults; the grid contents stay undefined until written.
module voxel_grid_sphere_stamp_and_sample_unit #(
	parameter int MAX_DIM = 64,
	parameter int STAMP_RADIUS = 4,
	parameter int MAX_SAMPLE_ATOMS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	vgss_in_if.sink                      in,
	vgss_out_if.source                   out,
	input  logic                         cfg_we,
	input  logic [vgss_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [vgss_pkg::CoordW-1:0]  cfg_data
);
	import vgss_pkg::*;

	localparam int AxW   = $clog2(MAX_DIM);
	localparam int AddrW = 3 * AxW;
	localparam int Depth = 1 << AddrW;
	localparam int R2    = STAMP_RADIUS * STAMP_RADIUS;
	localparam int OffW  = $clog2(2 * STAMP_RADIUS + 1) + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CEN   = 4'd1;
	localparam logic [3:0] S_WALK  = 4'd2;
	localparam logic [3:0] S_SADDR = 4'd3;
	localparam logic [3:0] S_SRD   = 4'd4;
	localparam logic [3:0] S_SACC  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;
	localparam logic [3:0] S_ROUND = 4'd8;
	localparam logic [3:0] S_MUL   = 4'd9;

	logic [3:0] state_q;
	vgss_in_t item_q;

	// configuration registers
	logic signed [CoordW-1:0] org_q [3];
	logic [DimW-1:0] dim_q [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dim_q[i] <= DimW'(64);
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X: org_q[0] <= cfg_data;
				REG_ORIGIN_Y: org_q[1] <= cfg_data;
				REG_ORIGIN_Z: org_q[2] <= cfg_data;
				REG_DIM_X: dim_q[0] <= cfg_data[DimW-1:0];
				REG_DIM_Y: dim_q[1] <= cfg_data[DimW-1:0];
				REG_DIM_Z: dim_q[2] <= cfg_data[DimW-1:0];
				default: ;
			endcase
		end
	end

	// clamped dims, 10 bits covers up to 256 and sign of compares
	logic signed [9:0] dimc [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			dimc[i] = (int'(dim_q[i]) > MAX_DIM) ? 10'(MAX_DIM) : 10'(dim_q[i]);
	end

	// rounded center and offset coordinates
	logic signed [21:0] rel_q [3];
	logic signed [15:0] cen_q [3];
	logic neg_q;
	logic signed [OffW-1:0] off_q [3];
	logic [AddrW-1:0] addr_q;
	logic [19:0] yz_q;

	// grid ram
	logic ram_we;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [ValW-1:0] ram_wdata, ram_rdata;
	vgss_ram #(.Width(ValW), .Depth(Depth)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// current stamp point
	logic signed [16:0] pt [3];
	logic inb;
	logic [9:0] dsq;
	logic signed [ValW-1:0] sval;
	logic [AddrW+8:0] lin;
	always_comb begin
		inb = 1'b1;
		dsq = '0;
		for (int i = 0; i < 3; i++) begin
			pt[i] = 17'(cen_q[i]) + 17'(off_q[i]);
			if (pt[i] < 0 || pt[i] >= 17'(dimc[i])) inb = 1'b0;
			dsq = dsq + 10'(off_q[i] * off_q[i]);
		end
		if (int'(dsq) > R2) inb = 1'b0;
		// stamp value looked up from a small constant table over d
		sval = '0;
		for (int k = 0; k <= R2; k++)
			if (int'(dsq) == k) sval = ValW'(-1280 + (1280 * k) / R2);
		lin = (AddrW+9)'(pt[0][9:0]) + (AddrW+9)'(yz_q) * (AddrW+9)'(dimc[0]);
	end

	// sample accumulation
	logic signed [SumW-1:0] sum_q;
	logic [CntW-1:0] cnt_q;
	logic pois_q;
	logic sample_ok;
	always_comb begin
		sample_ok = !pois_q && !neg_q;
		for (int i = 0; i < 3; i++)
			if (17'(cen_q[i]) >= 17'(dimc[i])) sample_ok = 1'b0;
	end

	// serial divide of |sum| by count
	logic [SumW-1:0] quo_q;
	logic [CntW:0] rem_q;
	logic [4:0] dstep_q;
	logic [CntW:0] rem_sh;
	assign rem_sh = {rem_q[CntW-1:0], quo_q[SumW-1]};

	vgss_out_t res_q;
	logic out_v_q;
	assign out.valid = out_v_q;
	assign out.data = res_q;
	assign in.ready = (state_q == S_IDLE) && !out_v_q;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = item_q.voxel_value;
		ram_raddr = addr_q;
		if (state_q == S_WALK && inb) begin
			ram_we = 1'b1;
			ram_waddr = lin[AddrW-1:0];
			ram_wdata = sval;
		end else if (state_q == S_CEN && item_q.kind == KIND_WRITE &&
		             int'(item_q.voxel_index) < Depth) begin
			ram_we = 1'b1;
			ram_waddr = AddrW'(item_q.voxel_index);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= '0;
			cnt_q <= '0;
			pois_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out.valid && out.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in.valid && in.ready) begin
					item_q <= in.data;
					rel_q[0] <= 22'(in.data.atom_x) - 22'(org_q[0]);
					rel_q[1] <= 22'(in.data.atom_y) - 22'(org_q[1]);
					rel_q[2] <= 22'(in.data.atom_z) - 22'(org_q[2]);
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					for (int i = 0; i < 3; i++) cen_q[i] <= grid_round(rel_q[i]);
					neg_q <= rel_q[0] < 0 || rel_q[1] < 0 || rel_q[2] < 0;
					// a sample reads the center itself, a stamp starts at the cube corner
					for (int i = 0; i < 3; i++)
						off_q[i] <= (item_q.kind == KIND_SAMPLE) ? '0 : OffW'(-STAMP_RADIUS);
					state_q <= S_MUL;
				end
				S_MUL: begin
					// y + dim_y*z, clipped meaningless when out of range
					yz_q <= 20'(pt[1][9:0]) + 20'(pt[2][9:0]) * 20'(dimc[1]);
					state_q <= S_CEN;
				end
				S_CEN: begin
					unique case (item_q.kind)
						KIND_WRITE: state_q <= S_IDLE;
						KIND_STAMP: state_q <= item_q.is_fit_atom ? S_IDLE : S_WALK;
						KIND_SAMPLE: state_q <= S_SADDR;
						default: state_q <= S_IDLE;
					endcase
				end
				S_WALK: begin
					// x fastest, then y, then z; yz recomputed on row change
					if (off_q[0] != OffW'(STAMP_RADIUS)) begin
						off_q[0] <= off_q[0] + 1'b1;
					end else begin
						off_q[0] <= OffW'(-STAMP_RADIUS);
						if (off_q[1] != OffW'(STAMP_RADIUS)) begin
							off_q[1] <= off_q[1] + 1'b1;
							state_q <= S_MUL;
						end else if (off_q[2] != OffW'(STAMP_RADIUS)) begin
							off_q[1] <= OffW'(-STAMP_RADIUS);
							off_q[2] <= off_q[2] + 1'b1;
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SADDR: begin
					addr_q <= lin[AddrW-1:0];
					for (int i = 0; i < 3; i++) off_q[i] <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SACC;
				S_SACC: begin
					logic [CntW-1:0] nc;
					logic np;
					logic signed [SumW-1:0] ns;
					nc = cnt_q;
					np = pois_q;
					ns = sum_q;
					if (int'(cnt_q) >= MAX_SAMPLE_ATOMS) np = 1'b1;
					else begin
						nc = cnt_q + 1'b1;
						if (sample_ok) ns = sum_q + SumW'($signed(ram_rdata));
						else np = 1'b1;
					end
					sum_q <= ns;
					cnt_q <= nc;
					pois_q <= np;
					if (item_q.last_atom) begin
						quo_q <= ns[SumW-1] ? SumW'(-ns) : ns;
						rem_q <= '0;
						dstep_q <= '0;
						state_q <= np ? S_OUT : S_DIV;
					end else state_q <= S_IDLE;
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, cnt_q}) begin
						rem_q <= rem_sh - {1'b0, cnt_q};
						quo_q <= {quo_q[SumW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[SumW-2:0], 1'b0};
					end
					dstep_q <= dstep_q + 1'b1;
					if (int'(dstep_q) == SumW - 1) state_q <= S_OUT;
				end
				S_OUT: begin
					res_q.outside_box <= pois_q;
					res_q.mean_density <= pois_q ? '0 :
						(sum_q[SumW-1] ? -ValW'(quo_q[ValW-1:0]) : ValW'(quo_q[ValW-1:0]));
					out_v_q <= 1'b1;
					sum_q <= '0;
					cnt_q <= '0;
					pois_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/vgss_checker.sv
module vgss_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	// result held until transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	// accepted item drops ready next cycle
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
endmodule

bind voxel_grid_sphere_stamp_and_sample_unit vgss_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready)
);
